FILE: hw/rtl/lav_pkg.sv
package lav_pkg;

  localparam int MAX_FIXTURES    = 256;
  localparam int PROPERTIES      = 8;
  localparam int MAX_ASSIGNMENTS = 1024;

  localparam int KEY_SPACE = MAX_FIXTURES * PROPERTIES;
  localparam int KEY_W     = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
  localparam int IDX_W     = (MAX_ASSIGNMENTS > 1) ? $clog2(MAX_ASSIGNMENTS) : 1;
  localparam int EPOCH_W   = 8;
  localparam int ENTRY_W   = EPOCH_W + IDX_W;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic [1:0] MODE_SET = 2'd0;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_TOO_MANY  = 3'd1,
    ERR_FIXTURE   = 3'd2,
    ERR_PROPERTY  = 3'd3,
    ERR_VALUE     = 3'd4,
    ERR_DUPLICATE = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_CLEAR
  } back_state_t;

  typedef struct packed {
    logic [15:0] fixture_number;
    logic [3:0]  property_code;
    logic [1:0]  value_mode;
    logic [31:0] level_bits;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [15:0] error_index;
    logic [15:0] owner_index;
  } result_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [15:0]      index;
    logic [15:0]      count;
    logic [KEY_W-1:0] key;
    logic             check;
    err_code_t        kind;
    logic             last;
  } cmd_t;

endpackage

FILE: hw/rtl/lav_ram.sv
module lav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lav_front.sv
module lav_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lav_pkg::item_t item,
  input  logic           clearing,
  input  logic           q_full,
  output logic           q_push,
  output lav_pkg::cmd_t  q_data
);
  import lav_pkg::*;

  logic [15:0] count;
  logic [15:0] count_next;
  logic [15:0] count_inc;
  logic        level_ok;
  err_code_t   kind;

  assign full   = q_full || clearing;
  assign q_push = push && !full;

  // saturate at the top of the 16-bit range
  assign count_inc = (count != 16'hFFFF) ? (count + 16'd1) : count;

  // -0 passes; other negatives, NaN, infinity and anything above 1.0 fail
  assign level_ok = (item.level_bits[30:0] == 31'd0) ||
                    (!item.level_bits[31] && (item.level_bits <= 32'h3F80_0000));

  always_comb begin
    if (item.fixture_number >= 16'(MAX_FIXTURES)) begin
      kind = ERR_FIXTURE;
    end else if (item.property_code >= 4'(PROPERTIES)) begin
      kind = ERR_PROPERTY;
    end else if ((item.value_mode == MODE_SET) && !level_ok) begin
      kind = ERR_VALUE;
    end else begin
      kind = ERR_OK;
    end
  end

  always_comb begin
    q_data.index = count;
    q_data.count = count_inc;
    q_data.key   = KEY_W'(32'(item.fixture_number) * PROPERTIES + 32'(item.property_code));
    q_data.check = ({1'b0, count} < 17'(MAX_ASSIGNMENTS));
    q_data.kind  = kind;
    q_data.last  = item.last;
  end

  always_comb begin
    count_next = count;
    if (q_push) begin
      count_next = item.last ? 16'd0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 16'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/lav_queue.sv
module lav_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lav_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lav_pkg::cmd_t head
);
  import lav_pkg::*;

  cmd_t       slots [2];
  logic [1:0] used;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign full    = (used == 2'd2);
  assign empty   = (used == 2'd0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        used <= used + 2'd1;
      end else if (do_pop && !do_push) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/lav_back.sv
module lav_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lav_pkg::cmd_t    q_head,
  output logic             q_pop,
  output logic             clearing,
  output logic             empty,
  input  logic             pop,
  output lav_pkg::result_t result
);
  import lav_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [EPOCH_W-1:0] epoch;
  logic [KEY_W-1:0]   clr_addr;
  cmd_t               cur;
  logic               latched;
  logic [2:0]         lat_code;
  logic [15:0]        lat_index;
  logic [15:0]        lat_owner;
  logic               out_valid;
  result_t            out_res;

  logic               ram_we;
  logic [KEY_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               take;
  logic               need_lookup;
  logic               done;
  logic               finish;
  logic               clr_done;
  logic               dup;
  cmd_t               sel;
  logic               set_err;
  logic [2:0]         new_code;
  logic [15:0]        new_owner;
  logic               eff_latched;
  logic [2:0]         eff_code;
  logic [15:0]        eff_index;
  logic [15:0]        eff_owner;
  result_t            res_next;

  lav_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_SPACE)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_head.key),
    .rdata (ram_rdata)
  );

  // a last request waits until the result register is free
  assign take        = (state == BK_IDLE) && !q_empty && (!q_head.last || !out_valid);
  assign need_lookup = !latched && q_head.check && (q_head.kind == ERR_OK);
  assign clr_done    = (clr_addr == KEY_W'(KEY_SPACE - 1));
  assign sel         = (state == BK_LOOKUP) ? cur : q_head;
  assign done        = (take && !need_lookup) || (state == BK_LOOKUP);
  assign finish      = done && sel.last;
  assign dup         = (state == BK_LOOKUP) &&
                       (ram_rdata[ENTRY_W-1 -: EPOCH_W] == epoch);

  assign q_pop    = take;
  assign clearing = (state == BK_CLEAR);
  assign empty    = !out_valid;
  assign result   = out_res;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          if (need_lookup) begin
            state_next = BK_LOOKUP;
          end else if (finish && (epoch == EPOCH_LAST)) begin
            state_next = BK_CLEAR;
          end
        end
      end
      BK_LOOKUP: begin
        if (finish && (epoch == EPOCH_LAST)) begin
          state_next = BK_CLEAR;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        if (clr_done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.key;
    ram_wdata = {epoch, cur.index[IDX_W-1:0]};
    unique case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      BK_LOOKUP: begin
        ram_we = !dup;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // error seen by the request that completes this cycle
  always_comb begin
    if (state == BK_LOOKUP) begin
      set_err   = dup;
      new_code  = ERR_DUPLICATE;
      new_owner = 16'(ram_rdata[IDX_W-1:0]);
    end else begin
      set_err   = done && !latched && sel.check && (sel.kind != ERR_OK);
      new_code  = sel.kind;
      new_owner = sel.index;
    end
    eff_latched = latched || set_err;
    eff_code    = latched ? lat_code  : new_code;
    eff_index   = latched ? lat_index : sel.index;
    eff_owner   = latched ? lat_owner : new_owner;

    if ({1'b0, sel.count} > 17'(MAX_ASSIGNMENTS)) begin
      res_next.error_code  = ERR_TOO_MANY;
      res_next.error_index = sel.count;
      res_next.owner_index = 16'd0;
    end else if (eff_latched) begin
      res_next.error_code  = eff_code;
      res_next.error_index = eff_index;
      res_next.owner_index = eff_owner;
    end else begin
      res_next.error_code  = ERR_OK;
      res_next.error_index = 16'd0;
      res_next.owner_index = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_head;
    end
    if (finish) begin
      out_res <= res_next;
    end
    if (set_err && !latched) begin
      lat_code  <= new_code;
      lat_index <= sel.index;
      lat_owner <= new_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      epoch     <= EPOCH_FIRST;
      clr_addr  <= '0;
      latched   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_done ? '0 : (clr_addr + KEY_W'(1));
        if (clr_done) begin
          epoch <= EPOCH_FIRST;
        end
      end else if (finish && (epoch != EPOCH_LAST)) begin
        epoch <= epoch + EPOCH_W'(1);
      end
      if (finish) begin
        latched <= 1'b0;
      end else if (set_err) begin
        latched <= 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR) |-> !q_pop)
    else $error("request taken during table clear");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch zero marks cleared entries and must not be live");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> !out_valid)
    else $error("result overwrites one not yet taken");

  a_lookup_after_take: assert property (@(posedge clk) disable iff (rst)
    (state == BK_LOOKUP) |-> $past(q_pop))
    else $error("lookup without a taken request");
`endif

endmodule

FILE: hw/rtl/look_assignment_validator.sv
// Look assignment validator.
// Input queue side: present an item and raise push; it is taken at a clock
// edge with push high and full low. Each item is one assignment of a look;
// the item with last set closes the look.
// Result queue side: while empty is low, result holds the verdict of the
// oldest finished look; raise pop to take it. One result per look.
// Items pass through a two-entry queue into the checker. An item that needs
// an owner-table lookup is read from the owner RAM as it is taken, then
// compared and written in the lookup state; other items finish as taken.
// The registered read of the owner RAM is why the lookup state is needed.
// A look's result is registered as its last item finishes in the checker.
// After reset, and again after every 255 looks, all 2048 entries of the
// owner table are swept, one entry a cycle; full stays high meanwhile.
// If the result is not popped, the next look's last item waits in the queue,
// and full rises once the queue fills; earlier items keep being checked.
module look_assignment_validator (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lav_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output lav_pkg::result_t result
);
  import lav_pkg::*;

  logic clearing;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_head;

  lav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  lav_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  lav_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
